// ===== rtl/wshc_pkg.sv =====
package wshc_pkg;

    localparam int DEF_SAMPLE_BITS = 10;
    localparam int DEF_COUNT_BITS  = 32;

    localparam int TICK_BITS  = 17;
    localparam int TOTAL_BITS = 32;
    localparam int TICK_LIMIT = 65535;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam int LEFT_LOW_RESET   = 500;
    localparam int LEFT_HIGH_RESET  = 600;
    localparam int RIGHT_LOW_RESET  = 550;
    localparam int RIGHT_HIGH_RESET = 650;

    typedef enum logic [1:0] {
        REG_LEFT_LOW   = 2'd0,
        REG_LEFT_HIGH  = 2'd1,
        REG_RIGHT_LOW  = 2'd2,
        REG_RIGHT_HIGH = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        LVL_LOWER = 2'd0,
        LVL_UPPER = 2'd1,
        LVL_UNDEF = 2'd2
    } level_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

endpackage

// ===== rtl/wshc_channel.sv =====
module wshc_channel #(
    parameter int SAMPLE_BITS = wshc_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = wshc_pkg::DEF_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  logic                                 is_read,
    input  logic signed [SAMPLE_BITS:0]          sample,
    input  logic        [SAMPLE_BITS-1:0]        low_bound,
    input  logic        [SAMPLE_BITS-1:0]        high_bound,
    output logic                                 level,
    output logic signed [wshc_pkg::TICK_BITS-1:0] ticks,
    output logic        [wshc_pkg::TOTAL_BITS-1:0] total
);

    localparam int MAG_BITS  = SAMPLE_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int DIFF_BITS = (COUNT_BITS > wshc_pkg::TICK_BITS) ? COUNT_BITS
                                                                   : wshc_pkg::TICK_BITS;

    wshc_pkg::level_t        trigger_reg, trigger_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   count_at_read_reg, count_at_read_next;
    logic                    reverse_reg, reverse_next;

    logic                    neg;
    logic [MAG_BITS-1:0]     mag;
    logic [SUM_BITS-1:0]     bound_sum;
    logic [SUM_BITS-1:0]     mag_twice;
    logic [COUNT_BITS-1:0]   diff;
    logic [DIFF_BITS-1:0]    diff_wide;
    logic [wshc_pkg::TICK_BITS-1:0] sat;

    assign neg       = sample[SAMPLE_BITS];
    assign mag       = neg ? MAG_BITS'(-sample) : MAG_BITS'(sample);
    assign bound_sum = SUM_BITS'(low_bound) + SUM_BITS'(high_bound);
    assign mag_twice = {mag, 1'b0};

    assign diff      = count_reg - count_at_read_reg;
    assign diff_wide = DIFF_BITS'(diff);
    assign sat       = (diff_wide > DIFF_BITS'(wshc_pkg::TICK_LIMIT))
                       ? wshc_pkg::TICK_BITS'(wshc_pkg::TICK_LIMIT)
                       : wshc_pkg::TICK_BITS'(diff_wide);

    always_comb
    begin
        trigger_next       = trigger_reg;
        count_next         = count_reg;
        count_at_read_next = count_at_read_reg;
        reverse_next       = reverse_reg;
        ticks              = '0;

        if (is_read)
        begin
            count_at_read_next = count_reg;
            ticks = reverse_reg ? -sat : sat;
        end
        else
        begin
            unique case (trigger_reg)
                wshc_pkg::LVL_UNDEF:
                begin
                    // first sample settles the level against the midpoint, no count
                    trigger_next = (bound_sum > mag_twice) ? wshc_pkg::LVL_LOWER
                                                           : wshc_pkg::LVL_UPPER;
                end
                wshc_pkg::LVL_LOWER:
                begin
                    if (mag > MAG_BITS'(high_bound))
                    begin
                        trigger_next = wshc_pkg::LVL_UPPER;
                        count_next   = count_reg + 1'b1;
                    end
                end
                wshc_pkg::LVL_UPPER:
                begin
                    if (mag < MAG_BITS'(low_bound))
                    begin
                        trigger_next = wshc_pkg::LVL_LOWER;
                        count_next   = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    trigger_next = wshc_pkg::LVL_UNDEF;
                end
            endcase

            // zero sample keeps the held direction
            if (neg)
                reverse_next = 1'b1;
            else if (mag != '0)
                reverse_next = 1'b0;
        end
    end

    assign level = (trigger_next == wshc_pkg::LVL_UPPER);
    assign total = wshc_pkg::TOTAL_BITS'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg       <= wshc_pkg::LVL_UNDEF;
            count_reg         <= '0;
            count_at_read_reg <= '0;
            reverse_reg       <= 1'b0;
        end
        else if (fire)
        begin
            trigger_reg       <= trigger_next;
            count_reg         <= count_next;
            count_at_read_reg <= count_at_read_next;
            reverse_reg       <= reverse_next;
        end
    end

endmodule

// ===== rtl/wheel_slot_hysteresis_counter.sv =====
// Channel   Handshake                      Payload
// input     in_valid / in_ready            action, left_sample, right_sample
// result    out_valid / out_ready          left_level, right_level, left_ticks,
//                                          right_ticks, left_total, right_total
// config    psel / penable / pwrite        paddr, pwdata, prdata (pready tied high)
//
// One item per cycle unless the result register stalls; an item taken into the input
// register passes to the result register after one pass of compare and count logic.
// Both channels update their trigger, count and direction in that single pass.
// Reset clears counts and direction and leaves both triggers at undefined level.
// A stalled result register holds the input register, which then stops taking items.
module wheel_slot_hysteresis_counter #(
    parameter int SAMPLE_BITS = wshc_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = wshc_pkg::DEF_COUNT_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic signed [SAMPLE_BITS:0]            left_sample,
    input  logic signed [SAMPLE_BITS:0]            right_sample,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   left_level,
    output logic                                   right_level,
    output logic signed [wshc_pkg::TICK_BITS-1:0]  left_ticks,
    output logic signed [wshc_pkg::TICK_BITS-1:0]  right_ticks,
    output logic        [wshc_pkg::TOTAL_BITS-1:0] left_total,
    output logic        [wshc_pkg::TOTAL_BITS-1:0] right_total,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [wshc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic        [wshc_pkg::DATA_BITS-1:0]  pwdata,
    output logic        [wshc_pkg::DATA_BITS-1:0]  prdata,
    output logic                                   pready
);

    logic [SAMPLE_BITS-1:0] left_low_reg, left_high_reg;
    logic [SAMPLE_BITS-1:0] right_low_reg, right_high_reg;
    wshc_pkg::reg_index_t   reg_index;
    logic                   cfg_write;

    logic                          stage_valid_reg;
    wshc_pkg::action_t             stage_action_reg;
    logic signed [SAMPLE_BITS:0]   stage_left_reg, stage_right_reg;
    logic                          stage_fire;
    logic                          stage_is_read;

    logic                                   left_level_next, right_level_next;
    logic signed [wshc_pkg::TICK_BITS-1:0]  left_ticks_next, right_ticks_next;
    logic        [wshc_pkg::TOTAL_BITS-1:0] left_total_next, right_total_next;

    logic                                   out_valid_reg;
    logic                                   left_level_reg, right_level_reg;
    logic signed [wshc_pkg::TICK_BITS-1:0]  left_ticks_reg, right_ticks_reg;
    logic        [wshc_pkg::TOTAL_BITS-1:0] left_total_reg, right_total_reg;

    // configuration port
    assign pready    = 1'b1;
    assign reg_index = wshc_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_index)
            wshc_pkg::REG_LEFT_LOW:   prdata = wshc_pkg::DATA_BITS'(left_low_reg);
            wshc_pkg::REG_LEFT_HIGH:  prdata = wshc_pkg::DATA_BITS'(left_high_reg);
            wshc_pkg::REG_RIGHT_LOW:  prdata = wshc_pkg::DATA_BITS'(right_low_reg);
            wshc_pkg::REG_RIGHT_HIGH: prdata = wshc_pkg::DATA_BITS'(right_high_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_low_reg   <= SAMPLE_BITS'(wshc_pkg::LEFT_LOW_RESET);
            left_high_reg  <= SAMPLE_BITS'(wshc_pkg::LEFT_HIGH_RESET);
            right_low_reg  <= SAMPLE_BITS'(wshc_pkg::RIGHT_LOW_RESET);
            right_high_reg <= SAMPLE_BITS'(wshc_pkg::RIGHT_HIGH_RESET);
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                wshc_pkg::REG_LEFT_LOW:   left_low_reg   <= pwdata[SAMPLE_BITS-1:0];
                wshc_pkg::REG_LEFT_HIGH:  left_high_reg  <= pwdata[SAMPLE_BITS-1:0];
                wshc_pkg::REG_RIGHT_LOW:  right_low_reg  <= pwdata[SAMPLE_BITS-1:0];
                wshc_pkg::REG_RIGHT_HIGH: right_high_reg <= pwdata[SAMPLE_BITS-1:0];
                default:                  left_low_reg   <= left_low_reg;
            endcase
        end
    end

    // input register advances whenever the result register is free or draining
    assign stage_fire    = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !stage_valid_reg || stage_fire;
    assign stage_is_read = (stage_action_reg == wshc_pkg::ACT_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_action_reg <= wshc_pkg::action_t'(action);
            stage_left_reg   <= left_sample;
            stage_right_reg  <= right_sample;
        end
    end

    wshc_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (stage_fire),
        .is_read    (stage_is_read),
        .sample     (stage_left_reg),
        .low_bound  (left_low_reg),
        .high_bound (left_high_reg),
        .level      (left_level_next),
        .ticks      (left_ticks_next),
        .total      (left_total_next)
    );

    wshc_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (stage_fire),
        .is_read    (stage_is_read),
        .sample     (stage_right_reg),
        .low_bound  (right_low_reg),
        .high_bound (right_high_reg),
        .level      (right_level_next),
        .ticks      (right_ticks_next),
        .total      (right_total_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            left_level_reg  <= left_level_next;
            right_level_reg <= right_level_next;
            left_ticks_reg  <= left_ticks_next;
            right_ticks_reg <= right_ticks_next;
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_level  = left_level_reg;
    assign right_level = right_level_reg;
    assign left_ticks  = left_ticks_reg;
    assign right_ticks = right_ticks_reg;
    assign left_total  = left_total_reg;
    assign right_total = right_total_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int SB = wshc_pkg::DEF_SAMPLE_BITS;
    localparam int TB_TICK_BITS  = wshc_pkg::TICK_BITS;
    localparam int TB_TOTAL_BITS = wshc_pkg::TOTAL_BITS;
    localparam int RANDOM_PER_SET = 162;

    typedef struct packed {
        logic                     left_level;
        logic                     right_level;
        logic [TB_TICK_BITS-1:0]  left_ticks;
        logic [TB_TICK_BITS-1:0]  right_ticks;
        logic [TB_TOTAL_BITS-1:0] left_total;
        logic [TB_TOTAL_BITS-1:0] right_total;
    } wheel_report_t;

    typedef struct {
        wshc_pkg::level_t         level;
        logic [TB_TOTAL_BITS-1:0] count;
        logic [TB_TOTAL_BITS-1:0] count_at_read;
        logic                     reverse;
    } wheel_state_t;

    // pairs > 0: alternate zero samples with these samples, that many times
    typedef struct packed {
        wshc_pkg::action_t act;
        logic [SB:0]       ls;
        logic [SB:0]       rs;
        int                pairs;
        bit                typed;
        wheel_report_t     want;
    } probe_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    action = wshc_pkg::ACT_SAMPLE;
    logic signed [SB:0]      left_sample = '0;
    logic signed [SB:0]      right_sample = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    left_level;
    logic                    right_level;
    logic signed [TB_TICK_BITS-1:0] left_ticks;
    logic signed [TB_TICK_BITS-1:0] right_ticks;
    logic [TB_TOTAL_BITS-1:0] left_total;
    logic [TB_TOTAL_BITS-1:0] right_total;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [wshc_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [wshc_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [wshc_pkg::DATA_BITS-1:0] prdata;
    logic                    pready;

    wheel_slot_hysteresis_counter DUT (.*);

    wheel_state_t  wheel [2];
    logic [SB-1:0] bounds [4];
    wheel_report_t due_reports [$];

    int feed_gap = 0;
    int drain_gap = 0;
    int mismatches = 0;
    int items_driven = 0;
    int reports_checked = 0;
    int bound_writes = 0;

    logic [SB-1:0] bound_sets [4][4] = '{
        '{10'd0,   10'd1023, 10'd1023, 10'd0},
        '{10'd700, 10'd300,  10'd1023, 10'd1023},
        '{10'd400, 10'd600,  10'd0,    10'd0},
        '{10'd0,   10'd0,    10'd0,    10'd0}
    };

    // reset bounds: left 500/600, right 550/650
    probe_t probes [19] = '{
        '{wshc_pkg::ACT_READ,   11'h400,      11'sd1023,   0, 1'b1,
          '{1'b0, 1'b0, 17'sd0, 17'sd0, 32'd0, 32'd0}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd550,     11'sd599,    0, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 32'd0, 32'd0}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd500,     11'sd650,    0, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 32'd0, 32'd0}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd499,     11'sd651,    0, 1'b1,
          '{1'b0, 1'b1, 17'sd0, 17'sd0, 32'd1, 32'd1}},
        '{wshc_pkg::ACT_SAMPLE, 11'h400,      11'sd0,      0, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 32'd2, 32'd2}},
        '{wshc_pkg::ACT_READ,   11'sd0,       11'sd0,      0, 1'b1,
          '{1'b1, 1'b0, -17'sd2, 17'sd2, 32'd2, 32'd2}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd0,       -11'sd1,     0, 1'b1,
          '{1'b0, 1'b0, 17'sd0, 17'sd0, 32'd3, 32'd2}},
        '{wshc_pkg::ACT_READ,   -11'sd1,      -11'sd1,     0, 1'b1,
          '{1'b0, 1'b0, -17'sd1, 17'sd0, 32'd3, 32'd2}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd1023,    -11'sd1023,  0, 1'b1,
          '{1'b1, 1'b1, 17'sd0, 17'sd0, 32'd4, 32'd3}},
        '{wshc_pkg::ACT_SAMPLE, -11'sd1023,   11'sd1023,   4, 1'b0, '0},
        '{wshc_pkg::ACT_READ,   11'sd0,       11'sd0,      0, 1'b1,
          '{1'b1, 1'b1, -17'sd9, 17'sd9, 32'd12, 32'd11}},
        '{wshc_pkg::ACT_READ,   11'sd0,       11'sd0,      0, 1'b1,
          '{1'b1, 1'b1, 17'sd0, 17'sd0, 32'd12, 32'd11}},
        '{wshc_pkg::ACT_SAMPLE, 11'sd600,     11'sd549,    0, 1'b0, '0},
        '{wshc_pkg::ACT_SAMPLE, 11'sd1,       11'h400,     0, 1'b0, '0},
        '{wshc_pkg::ACT_SAMPLE, -11'sd1023,   11'sd1,      0, 1'b0, '0},
        '{wshc_pkg::ACT_SAMPLE, 11'sd601,     11'sd651,    0, 1'b0, '0},
        '{wshc_pkg::ACT_READ,   11'sd0,       11'sd0,      0, 1'b0, '0},
        '{wshc_pkg::ACT_SAMPLE, 11'sd499,     11'sd549,    0, 1'b0, '0},
        '{wshc_pkg::ACT_READ,   11'sd0,       11'sd0,      0, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_wheels();
        for (int c = 0; c < 2; c++)
        begin
            wheel[c].level = wshc_pkg::LVL_UNDEF;
            wheel[c].count = '0;
            wheel[c].count_at_read = '0;
            wheel[c].reverse = 1'b0;
        end
        bounds[wshc_pkg::REG_LEFT_LOW]   = SB'(wshc_pkg::LEFT_LOW_RESET);
        bounds[wshc_pkg::REG_LEFT_HIGH]  = SB'(wshc_pkg::LEFT_HIGH_RESET);
        bounds[wshc_pkg::REG_RIGHT_LOW]  = SB'(wshc_pkg::RIGHT_LOW_RESET);
        bounds[wshc_pkg::REG_RIGHT_HIGH] = SB'(wshc_pkg::RIGHT_HIGH_RESET);
    endfunction

    function automatic void sample_channel(int ch, logic [SB:0] raw,
                                           logic [SB-1:0] lo, logic [SB-1:0] hi);
        logic [SB:0] mag;
        mag = raw[SB] ? (~raw + 1'b1) : raw;
        case (wheel[ch].level)
            wshc_pkg::LVL_UNDEF:
                wheel[ch].level = (int'(lo) + int'(hi) > 2 * int'(mag))
                                  ? wshc_pkg::LVL_LOWER : wshc_pkg::LVL_UPPER;
            wshc_pkg::LVL_LOWER:
                if (mag > hi)
                begin
                    wheel[ch].level = wshc_pkg::LVL_UPPER;
                    wheel[ch].count = wheel[ch].count + 1'b1;
                end
            default:
                if (mag < lo)
                begin
                    wheel[ch].level = wshc_pkg::LVL_LOWER;
                    wheel[ch].count = wheel[ch].count + 1'b1;
                end
        endcase
        // a zero sample keeps the held direction
        if (raw[SB])
            wheel[ch].reverse = 1'b1;
        else if (mag != 0)
            wheel[ch].reverse = 1'b0;
    endfunction

    function automatic logic [TB_TICK_BITS-1:0] read_channel(int ch);
        logic [TB_TOTAL_BITS-1:0] diff;
        diff = wheel[ch].count - wheel[ch].count_at_read;
        if (diff > wshc_pkg::TICK_LIMIT)
            diff = wshc_pkg::TICK_LIMIT;
        wheel[ch].count_at_read = wheel[ch].count;
        return wheel[ch].reverse ? TB_TICK_BITS'(-diff) : TB_TICK_BITS'(diff);
    endfunction

    function automatic wheel_report_t step_wheels(wshc_pkg::action_t act,
                                                  logic [SB:0] ls, logic [SB:0] rs);
        wheel_report_t r;
        r = '0;
        if (act == wshc_pkg::ACT_SAMPLE)
        begin
            sample_channel(0, ls, bounds[wshc_pkg::REG_LEFT_LOW],
                           bounds[wshc_pkg::REG_LEFT_HIGH]);
            sample_channel(1, rs, bounds[wshc_pkg::REG_RIGHT_LOW],
                           bounds[wshc_pkg::REG_RIGHT_HIGH]);
        end
        else
        begin
            r.left_ticks  = read_channel(0);
            r.right_ticks = read_channel(1);
        end
        r.left_level  = (wheel[0].level == wshc_pkg::LVL_UPPER);
        r.right_level = (wheel[1].level == wshc_pkg::LVL_UPPER);
        r.left_total  = wheel[0].count;
        r.right_total = wheel[1].count;
        return r;
    endfunction

    function automatic void check_field(string what, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic void check_report();
        wheel_report_t want;
        if (due_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: result item arrived with nothing outstanding", $time);
        end
        else
        begin
            want = due_reports.pop_front();
            reports_checked++;
            check_field("left_level", want.left_level, left_level);
            check_field("right_level", want.right_level, right_level);
            check_field("left_ticks", $signed(want.left_ticks), left_ticks);
            check_field("right_ticks", $signed(want.right_ticks), right_ticks);
            check_field("left_total", want.left_total, left_total);
            check_field("right_total", want.right_total, right_total);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_report();
        out_ready <= ($urandom_range(99) >= drain_gap);
    end

    function automatic logic [SB:0] pick_sample(logic [SB-1:0] lo, logic [SB-1:0] hi);
        int mag;
        case ($urandom_range(9))
            0, 1, 2, 3: return (SB+1)'($urandom);
            4, 5:       mag = int'(lo) + int'($urandom_range(4)) - 2;
            6, 7:       mag = int'(hi) + int'($urandom_range(4)) - 2;
            default:
                case ($urandom_range(3))
                    0:       mag = 0;
                    1:       mag = 1;
                    2:       mag = 1023;
                    default: mag = 1024;
                endcase
        endcase
        if (mag < 0)
            mag = 0;
        if (mag > 1024)
            mag = 1024;
        return $urandom_range(1) ? (SB+1)'(-mag) : (SB+1)'(mag);
    endfunction

    task automatic push_item(input wshc_pkg::action_t act, input logic [SB:0] ls,
                             input logic [SB:0] rs,
                             input bit typed, input wheel_report_t want);
        wheel_report_t pred;
        while ($urandom_range(99) < feed_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        left_sample  <= ls;
        right_sample <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = step_wheels(act, ls, rs);
        due_reports.push_back(typed ? want : pred);
        items_driven++;
    endtask

    // drain everything outstanding, then allow for the two-stage pipe
    task automatic settle();
        in_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // back-to-back transfers keep psel high; penable drops for each setup cycle
    task automatic apb_access(input logic wr, input wshc_pkg::reg_index_t idx,
                              input logic [wshc_pkg::DATA_BITS-1:0] wdata,
                              output logic [wshc_pkg::DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= wshc_pkg::ADDR_BITS'(4 * int'(idx));
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
    endtask

    task automatic set_bound(input wshc_pkg::reg_index_t idx, input logic [SB-1:0] value);
        logic [wshc_pkg::DATA_BITS-1:0] unused;
        // junk above the bound width must be dropped
        apb_access(1'b1, idx, ({$urandom} << SB) | wshc_pkg::DATA_BITS'(value), unused);
        bounds[idx] = value;
        bound_writes++;
    endtask

    task automatic readback_bounds();
        logic [wshc_pkg::DATA_BITS-1:0] got;
        for (int i = 0; i < 4; i++)
        begin
            apb_access(1'b0, wshc_pkg::reg_index_t'(i), '0, got);
            check_field($sformatf("register %0d readback", i), bounds[i], got);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int random_items;
        random_items = 0;
        clear_wheels();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        readback_bounds();

        feed_gap  = 28;
        drain_gap = 65;
        foreach (probes[i])
        begin
            if (probes[i].pairs > 0)
            begin
                // flip both triggers on every item
                repeat (probes[i].pairs)
                begin
                    push_item(wshc_pkg::ACT_SAMPLE, '0, '0, 1'b0, '0);
                    push_item(wshc_pkg::ACT_SAMPLE, probes[i].ls, probes[i].rs, 1'b0, '0);
                end
            end
            else
                push_item(probes[i].act, probes[i].ls, probes[i].rs,
                          probes[i].typed, probes[i].want);
        end

        for (int s = 0; s < 4; s++)
        begin
            settle();
            feed_gap  = (s < 2) ? 65 : 0;
            drain_gap = (s < 2) ? 28 : 0;
            for (int r = 0; r < 4; r++)
            begin
                if (s == 3)
                    bound_sets[s][r] = SB'($urandom_range(1023));
                set_bound(wshc_pkg::reg_index_t'(r), bound_sets[s][r]);
            end
            readback_bounds();
            repeat (RANDOM_PER_SET)
            begin
                push_item(($urandom_range(99) < 15) ? wshc_pkg::ACT_READ
                                                    : wshc_pkg::ACT_SAMPLE,
                          pick_sample(bounds[wshc_pkg::REG_LEFT_LOW],
                                      bounds[wshc_pkg::REG_LEFT_HIGH]),
                          pick_sample(bounds[wshc_pkg::REG_RIGHT_LOW],
                                      bounds[wshc_pkg::REG_RIGHT_HIGH]),
                          1'b0, '0);
                random_items++;
            end
        end
        settle();

        $display("Run covered %0d items (%0d random) and %0d result items compared,",
                 items_driven, random_items, reports_checked);
        $display("with %0d bound register writes over five threshold settings.", bound_writes);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== wheel_slot_hysteresis_counter.f =====
rtl/wshc_pkg.sv
rtl/wshc_channel.sv
rtl/wheel_slot_hysteresis_counter.sv
tb/sv/tb.sv
